@@ rtl/flim_pkg.sv @@
// Shared types, constants and the sine table generator of the phasor lifetime unit.
package flim_pkg;

  // Fixed-point constants: pi/2 in Q30 and 2*pi in Q29.
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [31:0] TWO_PI_Q29  = 32'd3373259426;

  // Divisors of the Taylor terms of the sine, (2i)*(2i+1).
  localparam longint unsigned TAYLOR_DIV [1:8] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
  };

  // Status codes of a result item.
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_EMPTY  = 3'd1;
  localparam logic [2:0] ST_NOINT  = 3'd2;
  localparam logic [2:0] ST_UZERO  = 3'd3;
  localparam logic [2:0] ST_MODONE = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] REG_BIN_WIDTH    = 2'd0;
  localparam logic [1:0] REG_WINDOW_START = 2'd1;
  localparam logic [1:0] REG_WINDOW_END   = 2'd2;
  localparam logic [1:0] REG_BACKGROUND   = 2'd3;

  // Output stream widths.
  localparam int OUT_DATA_W = 184;
  localparam int OUT_USER_W = 3;

  // Datapath commands issued by the controller.
  typedef enum logic [5:0] {
    OP_NONE,
    OP_LATCH,
    OP_DIV_PSTEP,
    OP_SET_PSTEP,
    OP_DIV_PVAL,
    OP_SET_PVAL,
    OP_PHASE_ZERO,
    OP_ACC,
    OP_ST_EMPTY,
    OP_ST_NOINT,
    OP_PERIOD,
    OP_DIV_U,
    OP_SET_U,
    OP_DIV_V,
    OP_SET_V,
    OP_SQU,
    OP_SQV,
    OP_TP_SIGN,
    OP_DEN_PH,
    OP_PROD_PH,
    OP_LIMB,
    OP_DIV_TP,
    OP_SET_TP,
    OP_TM_ZERO,
    OP_TM_MAX,
    OP_SQRT_A,
    OP_SET_A,
    OP_SQRT_B,
    OP_SET_B,
    OP_DEN_MOD,
    OP_PROD_MOD,
    OP_DIV_TM,
    OP_SET_TM,
    OP_MEAN,
    OP_EMIT
  } op_t;

  // Status returned by the datapath to the controller.
  typedef struct packed {
    logic first_bin;
    logic n_zero;
    logic last;
    logic isum_zero;
    logic u_zero;
    logic msq_ge;
    logic msq_zero;
    logic div_done;
    logic sqrt_done;
    logic limb_last;
    logic out_free;
  } dp_stat_t;

  // Sine in Q1.30 of an angle x in Q30, by a truncated Taylor series.
  function automatic logic [30:0] sin_poly(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int i = 1; i <= 8; i++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[i];
      if (i % 2 == 1) sum = sum - longint'(term);
      else            sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > (longint'(1) <<< 30)) sum = longint'(1) <<< 30;
    return 31'(sum);
  endfunction

endpackage

@@ rtl/flim_phasor_lifetime_unit.sv @@
// Top level of the phasor lifetime unit: controller, datapath and stream ports.
//
//  Channel   Direction  Handshake                  Payload
//  s_*       in         s_tvalid / s_tready        s_tdata: photon_count; s_tlast: last_bin
//  m_*       out        m_tvalid / m_tready        m_tdata: u, v, tau_phase, tau_mod, tau_mean;
//                                                  m_tuser: status
//  cfg_*     in         cfg_we, no back-pressure   cfg_index, cfg_data
//
// An ordinary bin goes through accept, first-bin check, sine table read, multiply and
// accumulate.
// The first bin of a curve adds two 64-step divisions for the phase step and the start phase,
// unless the window is empty. The last bin adds the end-of-curve work: up to four 64-step
// divisions in the shared divider and two 32-step roots.
// Reset is synchronous; the sine table is a constant ROM.
// A finished result waits in the output register; the next curve is taken meanwhile and
// the block only stalls when a further result is ready before the previous one is taken.
module flim_phasor_lifetime_unit
  import flim_pkg::*;
#(
  parameter int MAX_BINS         = 4096,
  parameter int TRIG_TABLE_DEPTH = 1024,
  parameter int SAMPLE_BITS      = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_data,
  // Histogram bins.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [15:0]           s_tdata,   // [15:0] photon_count
  input  logic                  s_tlast,   // last_bin
  // Results.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [31:0] u_coord, [63:32] v_coord, [103:64] tau_phase,
  // [142:104] tau_modulation, [182:143] tau_mean, [183] zero
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic [OUT_USER_W-1:0] m_tuser    // [2:0] status
);

  op_t      op;
  dp_stat_t stat;
  logic     accept;

  assign accept = s_tvalid && s_tready;

  // Sequencer.
  flim_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .op       (op)
  );

  // Arithmetic and state.
  flim_dp #(
    .MAX_BINS         (MAX_BINS),
    .TRIG_TABLE_DEPTH (TRIG_TABLE_DEPTH),
    .SAMPLE_BITS      (SAMPLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .count_in  (s_tdata),
    .last_in   (s_tlast),
    .op        (op),
    .stat      (stat),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_user  (m_tuser)
  );

endmodule

@@ rtl/flim_div.sv @@
// Iterative restoring divider, 128 by 64 bits, one quotient bit a cycle, saturating.
module flim_div
  import flim_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] hi,
  input  logic [63:0] lo,
  input  logic [63:0] d,
  input  logic [63:0] limit,
  output logic        done,
  output logic [63:0] q
);

  localparam logic [5:0] LAST_STEP = 6'd63;

  logic [63:0] rem;
  logic [63:0] lo_sh;
  logic [63:0] den;
  logic [63:0] lim;
  logic [63:0] quo;
  logic [5:0]  cnt;
  logic        busy;

  logic [64:0] shifted;
  logic [64:0] diff;
  logic        qbit;

  // One restoring step: shift in the next dividend bit and try the subtraction.
  assign shifted = {rem, lo_sh[63]};
  assign diff    = shifted - {1'b0, den};
  assign qbit    = shifted >= {1'b0, den};

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (d == 64'd0 || hi >= d) begin
          done <= 1'b1;
          busy <= 1'b0;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy && cnt == 6'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (start) begin
      den   <= d;
      lim   <= limit;
      rem   <= hi;
      lo_sh <= lo;
      cnt   <= LAST_STEP;
      if (d == 64'd0 || hi >= d) quo <= limit;
      else quo <= 64'd0;
    end else if (busy) begin
      rem   <= qbit ? diff[63:0] : shifted[63:0];
      lo_sh <= {lo_sh[62:0], 1'b0};
      quo   <= {quo[62:0], qbit};
      cnt   <= cnt - 6'd1;
    end
  end

  assign q = (quo > lim) ? lim : quo;

endmodule

@@ rtl/flim_sqrt.sv @@
// Iterative integer square root of a 64-bit value, one result bit a cycle.
module flim_sqrt
  import flim_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] x,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] xr;
  logic [63:0] res;
  logic [63:0] bit_r;
  logic        busy;
  logic [63:0] trial;

  assign trial = res + bit_r;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && bit_r[0]) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Digit-by-digit root: two radicand bits per step.
  always_ff @(posedge clk) begin
    if (start) begin
      xr    <= x;
      res   <= 64'd0;
      bit_r <= 64'd1 << 62;
    end else if (busy) begin
      if (xr >= trial) begin
        xr  <= xr - trial;
        res <= (res >> 1) + bit_r;
      end else begin
        res <= res >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign root = res[31:0];

endmodule

@@ rtl/flim_dp.sv @@
// Datapath: registers, window sums, sine table, shared multiplier, divider and root.
module flim_dp
  import flim_pkg::*;
#(
  parameter int MAX_BINS         = 4096,
  parameter int TRIG_TABLE_DEPTH = 1024,
  parameter int SAMPLE_BITS      = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_data,
  input  logic                  accept,
  input  logic [15:0]           count_in,
  input  logic                  last_in,
  input  op_t                   op,
  output dp_stat_t              stat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data,
  output logic [OUT_USER_W-1:0] out_user
);

  localparam int KW = $clog2(TRIG_TABLE_DEPTH + 1);
  localparam logic [63:0] CAP = (64'd1 << SAMPLE_BITS) - 64'd1;
  localparam logic [39:0] TAU_MAX = 40'h7F_FFFF_FFFF;
  localparam logic [39:0] TAU_MIN = 40'h80_0000_0000;

  // Configuration registers.
  logic [31:0] bin_width;
  logic [11:0] window_start;
  logic [12:0] window_end;
  logic [31:0] background;

  // Curve state.
  logic [12:0] bin_index;
  logic [47:0] intensity_sum;
  logic [63:0] cosine_sum;
  logic [63:0] sine_sum;
  logic [31:0] phase_step;
  logic [31:0] phase_value;

  // Latched item.
  logic [15:0] count_r;
  logic        last_r;

  // Work registers of the end-of-curve computation.
  logic [44:0]  period;
  logic [31:0]  u_r;
  logic [31:0]  v_r;
  logic [39:0]  tp_r;
  logic [38:0]  tm_r;
  logic [39:0]  tmean_r;
  logic [2:0]   st_r;
  logic [63:0]  msq;
  logic [63:0]  den;
  logic [31:0]  a_r;
  logic [31:0]  b_r;
  logic [63:0]  xm;
  logic [127:0] pacc;
  logic [1:0]   limb;

  // Output register.
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_USER_W-1:0] out_user_r;

  // Window bounds.
  logic [12:0] end_c;
  logic [12:0] n;
  logic        in_window;

  assign end_c = (32'(window_end) > 32'(MAX_BINS)) ? 13'(MAX_BINS) : window_end;
  assign n = (end_c > {1'b0, window_start}) ? end_c - {1'b0, window_start} : 13'd0;
  assign in_window = (bin_index >= {1'b0, window_start}) && (bin_index < end_c);

  // Background-corrected sample, Q16.16 signed.
  logic [15:0]        sample;
  logic signed [32:0] s_val;

  assign sample = ({48'd0, count_r} > CAP) ? CAP[15:0] : count_r;
  assign s_val  = $signed({1'b0, sample, 16'd0}) - $signed({1'b0, background});

  // Quarter-wave sine table, built at elaboration.
  logic [30:0] sin_rom [0:TRIG_TABLE_DEPTH];

  for (genvar g = 0; g <= TRIG_TABLE_DEPTH; g++) begin : g_rom
    localparam logic [63:0] XV =
      (HALF_PI_Q30 * 64'(g) + 64'(TRIG_TABLE_DEPTH / 2)) / 64'(TRIG_TABLE_DEPTH);
    assign sin_rom[g] = sin_poly(XV);
  end

  logic [63:0]   k_full;
  logic [KW-1:0] k_idx;
  logic [KW-1:0] kc_idx;
  logic [30:0]   sr_q;
  logic [30:0]   cr_q;
  logic [1:0]    quad_q;

  assign k_full = (64'(phase_value[29:0]) * 64'(TRIG_TABLE_DEPTH)) >> 30;
  assign k_idx  = k_full[KW-1:0];
  assign kc_idx = KW'(TRIG_TABLE_DEPTH) - k_idx;

  // Registered table reads.
  always_ff @(posedge clk) begin
    sr_q   <= sin_rom[k_idx];
    cr_q   <= sin_rom[kc_idx];
    quad_q <= phase_value[31:30];
  end

  // Quadrant folding.
  logic signed [31:0] c_val;
  logic signed [31:0] sn_val;
  logic signed [31:0] sr_s;
  logic signed [31:0] cr_s;

  assign sr_s = $signed({1'b0, sr_q});
  assign cr_s = $signed({1'b0, cr_q});

  always_comb begin
    case (quad_q)
      2'd0: begin
        sn_val = sr_s;
        c_val  = cr_s;
      end
      2'd1: begin
        sn_val = cr_s;
        c_val  = -sr_s;
      end
      2'd2: begin
        sn_val = -sr_s;
        c_val  = -cr_s;
      end
      default: begin
        sn_val = -cr_s;
        c_val  = sr_s;
      end
    endcase
  end

  // Weighted samples, registered.
  logic signed [64:0] pc_w;
  logic signed [64:0] ps_w;
  logic [63:0]        pc_q;
  logic [63:0]        ps_q;

  assign pc_w = s_val * c_val;
  assign ps_w = s_val * sn_val;

  always_ff @(posedge clk) begin
    pc_q <= pc_w[63:0];
    ps_q <= ps_w[63:0];
  end

  // Magnitudes and signs of the sums.
  logic [47:0] di;
  logic [63:0] mc;
  logic [63:0] ms;
  logic        neg_u;
  logic        neg_v;
  logic [31:0] au;
  logic [31:0] av;

  assign di    = intensity_sum[47] ? 48'd0 - intensity_sum : intensity_sum;
  assign mc    = cosine_sum[63] ? 64'd0 - cosine_sum : cosine_sum;
  assign ms    = sine_sum[63] ? 64'd0 - sine_sum : sine_sum;
  assign neg_u = cosine_sum[63] ^ intensity_sum[47];
  assign neg_v = sine_sum[63] ^ intensity_sum[47];
  assign au    = u_r[31] ? 32'd0 - u_r : u_r;
  assign av    = v_r[31] ? 32'd0 - v_r : v_r;

  // Shared 32 by 32 multiplier.
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;

  always_comb begin
    case (op)
      OP_PERIOD: begin
        mul_a = bin_width;
        mul_b = {19'd0, n};
      end
      OP_SQU: begin
        mul_a = au;
        mul_b = au;
      end
      OP_SQV: begin
        mul_a = av;
        mul_b = av;
      end
      OP_DEN_PH: begin
        mul_a = au;
        mul_b = TWO_PI_Q29;
      end
      OP_DEN_MOD: begin
        mul_a = b_r;
        mul_b = TWO_PI_Q29;
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Limb multiplier of the long product, 45 by 16 bits.
  logic [15:0] limb_val;
  logic [60:0] limb_p;

  assign limb_val = xm[{limb, 4'b0} +: 16];
  assign limb_p   = period * limb_val;

  // Divider operand selection.
  logic        div_start;
  logic [63:0] div_hi;
  logic [63:0] div_lo;
  logic [63:0] div_d;
  logic [63:0] div_lim;
  logic        div_done;
  logic [63:0] div_q;

  always_comb begin
    div_start = 1'b1;
    div_hi    = 64'd0;
    div_lo    = 64'd0;
    div_d     = {51'd0, n};
    div_lim   = '1;
    case (op)
      OP_DIV_PSTEP: div_lo = (64'd1 << 32) + 64'(n >> 1);
      OP_DIV_PVAL:  div_lo = (64'd1 << 31) + 64'(n >> 1);
      OP_DIV_U: begin
        div_hi  = mc >> 48;
        div_lo  = mc << 16;
        div_d   = {16'd0, di};
        div_lim = 64'd1 << 31;
      end
      OP_DIV_V: begin
        div_hi  = ms >> 48;
        div_lo  = ms << 16;
        div_d   = {16'd0, di};
        div_lim = 64'd1 << 31;
      end
      OP_DIV_TP: begin
        div_hi  = pacc[127:64];
        div_lo  = pacc[63:0];
        div_d   = den;
        div_lim = 64'd1 << 39;
      end
      OP_DIV_TM: begin
        div_hi  = pacc[127:64];
        div_lo  = pacc[63:0];
        div_d   = den;
        div_lim = 64'(TAU_MAX);
      end
      default: div_start = 1'b0;
    endcase
  end

  flim_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .hi    (div_hi),
    .lo    (div_lo),
    .d     (div_d),
    .limit (div_lim),
    .done  (div_done),
    .q     (div_q)
  );

  // Square root unit.
  logic        sqrt_start;
  logic [63:0] sqrt_x;
  logic        sqrt_done;
  logic [31:0] sqrt_root;

  assign sqrt_start = (op == OP_SQRT_A) || (op == OP_SQRT_B);
  assign sqrt_x     = (op == OP_SQRT_A) ? (64'd1 << 60) - msq : msq;

  flim_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .x     (sqrt_x),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  // Saturated coordinate from a quotient that is at most 2^31.
  logic [31:0] coord_sat_u;
  logic [31:0] coord_sat_v;

  assign coord_sat_u = neg_u ? 32'd0 - div_q[31:0]
                             : (div_q[31] ? 32'h7FFF_FFFF : div_q[31:0]);
  assign coord_sat_v = neg_v ? 32'd0 - div_q[31:0]
                             : (div_q[31] ? 32'h7FFF_FFFF : div_q[31:0]);

  logic        neg_tp;
  logic [39:0] tp_sat;
  logic [40:0] mean_sum;

  assign neg_tp   = u_r[31] ^ v_r[31];
  assign tp_sat   = neg_tp ? 40'd0 - div_q[39:0]
                           : (div_q[39] ? TAU_MAX : div_q[39:0]);
  assign mean_sum = {tp_r[39], tp_r} + {2'b00, tm_r};

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_width    <= 32'd65536;
      window_start <= 12'd0;
      window_end   <= 13'd256;
      background   <= 32'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BIN_WIDTH:    bin_width    <= cfg_data;
        REG_WINDOW_START: window_start <= cfg_data[11:0];
        REG_WINDOW_END:   window_end   <= cfg_data[12:0];
        REG_BACKGROUND:   background   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Curve state: phase accumulator, sums and bin counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_index     <= 13'd0;
      intensity_sum <= 48'd0;
      cosine_sum    <= 64'd0;
      sine_sum      <= 64'd0;
      phase_step    <= 32'd0;
      phase_value   <= 32'd0;
    end else begin
      case (op)
        OP_SET_PSTEP:  phase_step <= div_q[31:0];
        OP_SET_PVAL:   phase_value <= div_q[31:0];
        OP_PHASE_ZERO: begin
          phase_step  <= 32'd0;
          phase_value <= 32'd0;
        end
        OP_ACC: begin
          if (in_window) begin
            intensity_sum <= intensity_sum + {{15{s_val[32]}}, s_val};
            cosine_sum    <= cosine_sum + {{16{pc_q[63]}}, pc_q[63:16]};
            sine_sum      <= sine_sum + {{16{ps_q[63]}}, ps_q[63:16]};
            phase_value   <= phase_value + phase_step;
          end
          if (bin_index != 13'h1FFF) bin_index <= bin_index + 13'd1;
        end
        OP_EMIT: begin
          bin_index     <= 13'd0;
          intensity_sum <= 48'd0;
          cosine_sum    <= 64'd0;
          sine_sum      <= 64'd0;
        end
        default: ;
      endcase
    end
  end

  // End-of-curve work registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      count_r <= count_in;
      last_r  <= last_in;
    end
    case (op)
      OP_ST_EMPTY, OP_ST_NOINT: begin
        st_r    <= (op == OP_ST_EMPTY) ? ST_EMPTY : ST_NOINT;
        u_r     <= 32'd0;
        v_r     <= 32'd0;
        tp_r    <= 40'd0;
        tm_r    <= 39'd0;
        tmean_r <= 40'd0;
      end
      OP_PERIOD: begin
        period <= mul_p[44:0];
        st_r   <= ST_OK;
      end
      OP_SET_U:   u_r <= coord_sat_u;
      OP_SET_V:   v_r <= coord_sat_v;
      OP_SQU:     msq <= mul_p;
      OP_SQV:     msq <= msq + mul_p;
      OP_TP_SIGN: begin
        st_r <= ST_UZERO;
        if (v_r == 32'd0) tp_r <= 40'd0;
        else tp_r <= v_r[31] ? TAU_MIN : TAU_MAX;
      end
      OP_DEN_PH, OP_DEN_MOD: den <= mul_p;
      OP_PROD_PH, OP_PROD_MOD: begin
        xm   <= (op == OP_PROD_PH) ? {3'd0, av, 29'd0} : {3'd0, a_r, 29'd0};
        pacc <= 128'd0;
        limb <= 2'd3;
      end
      OP_LIMB: begin
        pacc <= {pacc[111:0], 16'd0} + {67'd0, limb_p};
        limb <= limb - 2'd1;
      end
      OP_SET_TP: tp_r <= tp_sat;
      OP_TM_ZERO: begin
        tm_r <= 39'd0;
        if (st_r == ST_OK) st_r <= ST_MODONE;
      end
      OP_TM_MAX: tm_r <= TAU_MAX[38:0];
      OP_SET_A:  a_r <= sqrt_root;
      OP_SET_B:  b_r <= sqrt_root;
      OP_SET_TM: tm_r <= div_q[38:0];
      OP_MEAN:   tmean_r <= mean_sum[40:1];
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op == OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_EMIT) begin
      out_data_r <= {1'b0, tmean_r, tm_r, tp_r, v_r, u_r};
      out_user_r <= st_r;
    end
  end

  assign out_data = out_data_r;
  assign out_user = out_user_r;

  // Status to the controller.
  always_comb begin
    stat.first_bin = (bin_index == 13'd0);
    stat.n_zero    = (n == 13'd0);
    stat.last      = last_r;
    stat.isum_zero = (intensity_sum == 48'd0);
    stat.u_zero    = (u_r == 32'd0);
    stat.msq_ge    = (msq[63:60] != 4'd0);
    stat.msq_zero  = (msq == 64'd0);
    stat.div_done  = div_done;
    stat.sqrt_done = sqrt_done;
    stat.limb_last = (limb == 2'd0);
    stat.out_free  = !out_valid || out_ready;
  end

endmodule

@@ rtl/flim_ctrl.sv @@
// Controller: sequences the per-bin accumulation and the end-of-curve computation.
module flim_ctrl
  import flim_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  dp_stat_t stat,
  output op_t      op
);

  typedef enum logic [5:0] {
    S_IDLE,
    S_FIRST,
    S_W_PSTEP,
    S_DIV_PVAL,
    S_W_PVAL,
    S_LOOK,
    S_MULT,
    S_ACC,
    S_END,
    S_DIV_U,
    S_W_U,
    S_DIV_V,
    S_W_V,
    S_SQU,
    S_SQV,
    S_PH_CHK,
    S_PROD_PH,
    S_LIMB_PH,
    S_DIV_TP,
    S_W_TP,
    S_MOD_CHK,
    S_W_A,
    S_SQRT_B,
    S_W_B,
    S_DEN_MOD,
    S_PROD_MOD,
    S_LIMB_MOD,
    S_DIV_TM,
    S_W_TM,
    S_MEAN,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == S_IDLE);

  // Next state and datapath command.
  always_comb begin
    state_next = state;
    op         = OP_NONE;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          op         = OP_LATCH;
          state_next = S_FIRST;
        end
      end
      S_FIRST: begin
        if (!stat.first_bin) begin
          state_next = S_LOOK;
        end else if (stat.n_zero) begin
          op         = OP_PHASE_ZERO;
          state_next = S_LOOK;
        end else begin
          op         = OP_DIV_PSTEP;
          state_next = S_W_PSTEP;
        end
      end
      S_W_PSTEP: begin
        if (stat.div_done) begin
          op         = OP_SET_PSTEP;
          state_next = S_DIV_PVAL;
        end
      end
      S_DIV_PVAL: begin
        op         = OP_DIV_PVAL;
        state_next = S_W_PVAL;
      end
      S_W_PVAL: begin
        if (stat.div_done) begin
          op         = OP_SET_PVAL;
          state_next = S_LOOK;
        end
      end
      S_LOOK: state_next = S_MULT;
      S_MULT: state_next = S_ACC;
      S_ACC: begin
        op         = OP_ACC;
        state_next = stat.last ? S_END : S_IDLE;
      end
      S_END: begin
        if (stat.n_zero) begin
          op         = OP_ST_EMPTY;
          state_next = S_EMIT;
        end else if (stat.isum_zero) begin
          op         = OP_ST_NOINT;
          state_next = S_EMIT;
        end else begin
          op         = OP_PERIOD;
          state_next = S_DIV_U;
        end
      end
      S_DIV_U: begin
        op         = OP_DIV_U;
        state_next = S_W_U;
      end
      S_W_U: begin
        if (stat.div_done) begin
          op         = OP_SET_U;
          state_next = S_DIV_V;
        end
      end
      S_DIV_V: begin
        op         = OP_DIV_V;
        state_next = S_W_V;
      end
      S_W_V: begin
        if (stat.div_done) begin
          op         = OP_SET_V;
          state_next = S_SQU;
        end
      end
      S_SQU: begin
        op         = OP_SQU;
        state_next = S_SQV;
      end
      S_SQV: begin
        op         = OP_SQV;
        state_next = S_PH_CHK;
      end
      S_PH_CHK: begin
        if (stat.u_zero) begin
          op         = OP_TP_SIGN;
          state_next = S_MOD_CHK;
        end else begin
          op         = OP_DEN_PH;
          state_next = S_PROD_PH;
        end
      end
      S_PROD_PH: begin
        op         = OP_PROD_PH;
        state_next = S_LIMB_PH;
      end
      S_LIMB_PH: begin
        op = OP_LIMB;
        if (stat.limb_last) state_next = S_DIV_TP;
      end
      S_DIV_TP: begin
        op         = OP_DIV_TP;
        state_next = S_W_TP;
      end
      S_W_TP: begin
        if (stat.div_done) begin
          op         = OP_SET_TP;
          state_next = S_MOD_CHK;
        end
      end
      S_MOD_CHK: begin
        if (stat.msq_ge) begin
          op         = OP_TM_ZERO;
          state_next = S_MEAN;
        end else if (stat.msq_zero) begin
          op         = OP_TM_MAX;
          state_next = S_MEAN;
        end else begin
          op         = OP_SQRT_A;
          state_next = S_W_A;
        end
      end
      S_W_A: begin
        if (stat.sqrt_done) begin
          op         = OP_SET_A;
          state_next = S_SQRT_B;
        end
      end
      S_SQRT_B: begin
        op         = OP_SQRT_B;
        state_next = S_W_B;
      end
      S_W_B: begin
        if (stat.sqrt_done) begin
          op         = OP_SET_B;
          state_next = S_DEN_MOD;
        end
      end
      S_DEN_MOD: begin
        op         = OP_DEN_MOD;
        state_next = S_PROD_MOD;
      end
      S_PROD_MOD: begin
        op         = OP_PROD_MOD;
        state_next = S_LIMB_MOD;
      end
      S_LIMB_MOD: begin
        op = OP_LIMB;
        if (stat.limb_last) state_next = S_DIV_TM;
      end
      S_DIV_TM: begin
        op         = OP_DIV_TM;
        state_next = S_W_TM;
      end
      S_W_TM: begin
        if (stat.div_done) begin
          op         = OP_SET_TM;
          state_next = S_MEAN;
        end
      end
      S_MEAN: begin
        op         = OP_MEAN;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          op         = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // A divider result only arrives while the controller waits for one.
  a_div_done_waiting: assert property (@(posedge clk) disable iff (rst)
    stat.div_done |-> (state == S_W_PSTEP || state == S_W_PVAL || state == S_W_U ||
                       state == S_W_V || state == S_W_TP || state == S_W_TM))
    else $error("divider finished outside a wait state");

  // A root result only arrives while the controller waits for one.
  a_sqrt_done_waiting: assert property (@(posedge clk) disable iff (rst)
    stat.sqrt_done |-> (state == S_W_A || state == S_W_B))
    else $error("square root finished outside a wait state");

  // A full output register holds the finished curve back.
  a_emit_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && !stat.out_free) |=> state == S_EMIT)
    else $error("result emitted over an untaken item");

  // An accepted item always starts the per-bin sequence.
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> state == S_FIRST)
    else $error("accepted item did not start processing");

endmodule
